// ===== rtl/core/lap3_pkg.sv =====
`timescale 1ns / 1ps

package lap3_pkg;

	// Default depth of each line store (pixels per row at most).
	localparam int DEF_MAX_WIDTH = 2048;

	localparam int CFG_BITS = 12;
	// Row position runs up to height+1, which needs one bit above the register.
	localparam int ROW_BITS = CFG_BITS + 1;

	localparam logic [CFG_BITS-1:0] RST_IMAGE_WIDTH  = 12'd640;
	localparam logic [CFG_BITS-1:0] RST_IMAGE_HEIGHT = 12'd480;
	localparam logic [CFG_BITS-1:0] MIN_DIM          = 12'd3;

	localparam logic CFG_IMAGE_WIDTH  = 1'b0;
	localparam logic CFG_IMAGE_HEIGHT = 1'b1;

	typedef struct packed {
		logic [7:0] pixel_in;
		logic       is_padding;
	} in_req_t;

	typedef struct packed {
		logic [7:0] pixel_out;
		logic       end_of_frame;
	} out_req_t;

endpackage

// ===== rtl/core/lap3_line_buf.sv =====
`timescale 1ns / 1ps

module lap3_line_buf #(
	parameter int MAX_WIDTH = lap3_pkg::DEF_MAX_WIDTH,
	parameter int ADDR_W    = $clog2(MAX_WIDTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [15:0]       wr_data,
	output logic [15:0]       rd_data
);

	// Upper byte is the row two above the input, lower byte the row just above.
	logic [15:0] mem [MAX_WIDTH];
	logic [15:0] rdata_q;
	logic [15:0] fwd_data_q;
	logic        fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// A read that lands on the entry written at the same edge sees old data,
	// so the write data is kept and used in its place.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_data_q <= wr_data;
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : rdata_q;

endmodule

// ===== rtl/core/laplacian_3x3_edge_filter.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_ready  lap3_pkg::in_req_t  (pixel_in, is_padding)
// out      output     out_valid/out_ready  lap3_pkg::out_req_t (pixel_out, end_of_frame)
// cfg      input      cfg_we               cfg_index, cfg_wdata (no read-back)
//
// One request per cycle is accepted unless the output stalls; requests pass the
// first stage and the output register. The line store is read when a request is
// taken and written back as it leaves the first stage, which sets the single-cycle
// rate; same-entry collisions are forwarded. Reset clears the window, the position
// counters and the pipeline valid bits; the line stores hold garbage until written.
// A stalled output holds one result while one more request waits in the first stage.

module laplacian_3x3_edge_filter #(
	parameter int MAX_WIDTH = lap3_pkg::DEF_MAX_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  lap3_pkg::in_req_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output lap3_pkg::out_req_t                out_data,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [lap3_pkg::CFG_BITS-1:0]     cfg_wdata
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int CMP_W = ($clog2(MAX_WIDTH + 1) > lap3_pkg::CFG_BITS) ?
		$clog2(MAX_WIDTH + 1) : lap3_pkg::CFG_BITS;
	localparam int ROW_W = lap3_pkg::ROW_BITS;

	logic [lap3_pkg::CFG_BITS-1:0] width_q;
	logic [lap3_pkg::CFG_BITS-1:0] height_q;
	logic [COL_W-1:0]              col_q;
	logic [ROW_W-1:0]              row_q;

	logic [CMP_W-1:0] w_eff;
	logic [CMP_W-1:0] w_last;
	logic [CMP_W-1:0] c_ext;
	logic [ROW_W-1:0] h_ext;
	logic [ROW_W-1:0] h_p1;

	logic accept;
	logic s1_adv;
	logic col_zero;
	logic have;
	logic eof;
	logic lap;

	logic             valid_s1;
	logic [7:0]       px_s1;
	logic [COL_W-1:0] addr_s1;
	logic             have_s1;
	logic             eof_s1;
	logic             lap_s1;

	logic [15:0] lb_rd_data;
	logic [7:0]  top;
	logic [7:0]  mid;
	logic        wr_en;

	logic [2:0][2:0][7:0] win_q;
	logic [10:0]          nbr_sum;
	logic [7:0]           center;
	logic [7:0]           lap_val;

	logic                 out_valid_q;
	lap3_pkg::out_req_t   out_data_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= lap3_pkg::RST_IMAGE_WIDTH;
			height_q <= lap3_pkg::RST_IMAGE_HEIGHT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lap3_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata;
				lap3_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q < lap3_pkg::MIN_DIM) begin
			w_eff = CMP_W'(lap3_pkg::MIN_DIM);
		end else if (CMP_W'(width_q) > CMP_W'(MAX_WIDTH)) begin
			w_eff = CMP_W'(MAX_WIDTH);
		end else begin
			w_eff = CMP_W'(width_q);
		end
		if (height_q < lap3_pkg::MIN_DIM) begin
			h_ext = ROW_W'(lap3_pkg::MIN_DIM);
		end else begin
			h_ext = ROW_W'(height_q);
		end
	end

	assign w_last = w_eff - CMP_W'(1);
	assign h_p1   = h_ext + ROW_W'(1);
	assign c_ext  = CMP_W'(col_q);

	assign s1_adv   = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || s1_adv;
	assign accept   = in_valid && in_ready;

	// Output position of this request: (row-2, last column) at row start,
	// otherwise (row-1, col-1).
	always_comb begin
		col_zero = (col_q == '0);
		have = 1'b0;
		eof  = 1'b0;
		lap  = 1'b0;
		if (col_zero) begin
			have = (row_q >= ROW_W'(2)) && (row_q < h_p1 + ROW_W'(1));
			eof  = (row_q == h_p1);
		end else begin
			have = (row_q >= ROW_W'(1)) && (row_q <= h_ext);
			lap  = !((row_q == ROW_W'(1)) || (row_q == h_ext) ||
				(col_q == COL_W'(1)) || (c_ext >= w_eff));
		end
	end

	// Raster position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_zero && (row_q >= h_p1)) begin
				col_q <= '0;
				row_q <= '0;
			end else if (c_ext >= w_last) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= in_data.is_padding ? 8'd0 : in_data.pixel_in;
			addr_s1 <= col_q;
			have_s1 <= have;
			eof_s1  <= eof;
			lap_s1  <= lap;
		end
	end

	assign wr_en = valid_s1 && s1_adv;

	lap3_line_buf #(
		.MAX_WIDTH (MAX_WIDTH),
		.ADDR_W    (COL_W)
	) u_line_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (col_q),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data ({mid, px_s1}),
		.rd_data (lb_rd_data)
	);

	assign top = lb_rd_data[15:8];
	assign mid = lb_rd_data[7:0];

	// Laplacian over the window as it stands after this request's shift.
	assign center  = win_q[1][2];
	assign nbr_sum = 11'(win_q[0][1]) + 11'(win_q[1][1]) + 11'(win_q[2][1]) +
		11'(win_q[0][2]) + 11'(win_q[2][2]) + 11'(top) + 11'(mid) + 11'(px_s1);
	assign lap_val = {center[4:0], 3'b000} - nbr_sum[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (wr_en) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k][0] <= win_q[k][1];
				win_q[k][1] <= win_q[k][2];
			end
			win_q[0][2] <= top;
			win_q[1][2] <= mid;
			win_q[2][2] <= px_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wr_en && have_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && have_s1) begin
			out_data_q.pixel_out    <= lap_s1 ? lap_val : center;
			out_data_q.end_of_frame <= eof_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef ASSERT_OFF
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled with an empty first stage");

	a_result_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s1) && $past(have_s1))
		else $error("result appeared without a request behind it");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && col_zero && (row_q >= h_p1) |=> (col_q == '0) && (row_q == '0))
		else $error("position did not return to frame start");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (CMP_W'(col_q) < CMP_W'(MAX_WIDTH)))
		else $error("column outside the line store");

	a_eof_at_row_start: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && eof_s1 |-> have_s1 && !lap_s1)
		else $error("frame end marked on a filtered pixel");
`endif

endmodule
